>>> sv/slpc_pkg.sv
// Shared types and constants for the status LED pattern controller.
// No dependencies; every other file depends on this package.
`default_nettype none

package slpc_pkg;

  localparam int unsigned TIMER_WIDTH = 16;
  localparam int unsigned BLINK_WIDTH = 4;
  localparam int unsigned CFG_WIDTH   = 16;
  localparam int unsigned CFG_IDX_W   = 3;

  // Mode encoding, shared by mode_code and mode_now
  typedef enum logic [1:0] {
    MODE_READY  = 2'd0,
    MODE_LISTEN = 2'd1,
    MODE_PROC   = 2'd2,
    MODE_RESULT = 2'd3
  } mode_e;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_READY_PULSE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_READY_PERIOD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_HALF = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_STEP = CFG_IDX_W'(3);

  localparam logic [CFG_WIDTH-1:0] RST_READY_PULSE  = CFG_WIDTH'(90);
  localparam logic [CFG_WIDTH-1:0] RST_READY_PERIOD = CFG_WIDTH'(1600);
  localparam logic [CFG_WIDTH-1:0] RST_PROC_HALF    = CFG_WIDTH'(140);
  localparam logic [CFG_WIDTH-1:0] RST_RESULT_STEP  = CFG_WIDTH'(120);

  typedef struct packed {
    logic [CFG_WIDTH-1:0] ready_on_ticks;
    logic [CFG_WIDTH-1:0] ready_len_ticks;
    logic [CFG_WIDTH-1:0] processing_half_ms;
    logic [CFG_WIDTH-1:0] result_step_ms;
  } cfg_t;

  // One item as held in the input register
  typedef struct packed {
    logic                   req_type;
    logic [1:0]             mode_code;
    logic [BLINK_WIDTH-1:0] blink_count;
  } item_t;

  // LED status after an item
  typedef struct packed {
    logic  led_on;
    mode_e mode_now;
  } status_t;

endpackage

`default_nettype wire

>>> sv/slpc_if.sv
// Handshake interfaces for the request and result channels.
// Depends on slpc_pkg for the blink field width.
`default_nettype none

interface slpc_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [1:0]                     mode_code;
  logic [slpc_pkg::BLINK_WIDTH-1:0] blink_count;

  modport source (output valid, output req_type, output mode_code, output blink_count,
                  input ready);
  modport sink   (input valid, input req_type, input mode_code, input blink_count,
                  output ready);
endinterface

interface slpc_rsp_if;
  logic       valid;
  logic       ready;
  logic       led_on;
  logic [1:0] mode_now;

  modport source (output valid, output led_on, output mode_now, input ready);
  modport sink   (input valid, input led_on, input mode_now, output ready);
endinterface

`default_nettype wire

>>> sv/slpc_cfg_regs.sv
// Configuration register file: four timing registers with reset defaults.
// Depends on slpc_pkg.
`default_nettype none

module slpc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [slpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [slpc_pkg::CFG_WIDTH-1:0]  cfg_wdata_i,
  output slpc_pkg::cfg_t                  cfg_o
);
  import slpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_READY_PULSE:  cfg_d.ready_on_ticks     = cfg_wdata_i;
        CFG_READY_PERIOD: cfg_d.ready_len_ticks    = cfg_wdata_i;
        CFG_PROC_HALF:    cfg_d.processing_half_ms = cfg_wdata_i;
        CFG_RESULT_STEP:  cfg_d.result_step_ms     = cfg_wdata_i;
        default:          cfg_d = cfg_q; // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ready_on_ticks     <= RST_READY_PULSE;
      cfg_q.ready_len_ticks    <= RST_READY_PERIOD;
      cfg_q.processing_half_ms <= RST_PROC_HALF;
      cfg_q.result_step_ms     <= RST_RESULT_STEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/slpc_core.sv
// Pattern state and its update for one item, registered when step_i is high.
// Depends on slpc_pkg; fed by the input register of the top level.
`default_nettype none

module slpc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  slpc_pkg::item_t   item_i,
  input  slpc_pkg::cfg_t    cfg_i,
  output slpc_pkg::status_t status_o
);
  import slpc_pkg::*;

  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

  mode_e                  mode_q, mode_d;
  logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
  logic                   phase_q, phase_d;
  logic [BLINK_WIDTH-1:0] target_q, target_d;
  logic [BLINK_WIDTH-1:0] done_q, done_d;
  logic                   led_q, led_d;

  logic [TIMER_WIDTH-1:0] adv;
  logic [BLINK_WIDTH-1:0] done_inc;
  logic                   go_ready;
  mode_e                  new_mode;

  always_comb begin
    adv      = (elapsed_q == TIMER_MAX) ? TIMER_MAX : elapsed_q + 1'b1;
    done_inc = done_q + 1'b1;
    new_mode = mode_e'(item_i.mode_code);

    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    phase_d   = phase_q;
    target_d  = target_q;
    done_d    = done_q;
    led_d     = led_q;
    go_ready  = 1'b0;

    if (item_i.req_type) begin
      // Set mode: restart every count
      mode_d    = new_mode;
      elapsed_d = '0;
      phase_d   = 1'b0;
      done_d    = '0;
      target_d  = (new_mode == MODE_RESULT) ? item_i.blink_count : '0;
      led_d     = (new_mode == MODE_LISTEN);
    end else begin
      case (mode_q)
        MODE_READY: begin
          elapsed_d = (adv >= cfg_i.ready_len_ticks) ? '0 : adv;
          led_d     = (elapsed_d < cfg_i.ready_on_ticks);
        end
        MODE_LISTEN: begin
          elapsed_d = adv;
          led_d     = 1'b1;
        end
        MODE_PROC: begin
          if (adv >= cfg_i.processing_half_ms) begin
            elapsed_d = '0;
            phase_d   = ~phase_q;
          end else begin
            elapsed_d = adv;
          end
          led_d = ~phase_d;
        end
        MODE_RESULT: begin
          if (done_q >= target_q) begin
            go_ready = 1'b1;
          end else if (adv < cfg_i.result_step_ms) begin
            elapsed_d = adv;
          end else begin
            elapsed_d = '0;
            if (!led_q) begin
              led_d = 1'b1;
            end else begin
              // Count a completed blink on each toggle to off
              led_d  = 1'b0;
              done_d = done_inc;
              go_ready = (done_inc >= target_q);
            end
          end
        end
        default: mode_d = mode_q;
      endcase

      if (go_ready) begin
        mode_d    = MODE_READY;
        elapsed_d = '0;
        phase_d   = 1'b0;
        done_d    = '0;
        target_d  = '0;
        led_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_READY;
      elapsed_q <= '0;
      phase_q   <= 1'b0;
      target_q  <= '0;
      done_q    <= '0;
      led_q     <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
      phase_q   <= phase_d;
      target_q  <= target_d;
      done_q    <= done_d;
      led_q     <= led_d;
    end
  end

  assign status_o.led_on   = led_d;
  assign status_o.mode_now = mode_d;

endmodule

`default_nettype wire

>>> sv/status_led_pattern_controller.sv
// Channel  Dir  Payload                              Handshake
// req      in   req_type, mode_code, blink_count     valid / ready
// rsp      out  led_on, mode_now                     valid / ready
// cfg      in   cfg_idx_i, cfg_wdata_i               cfg_we_i, no back-pressure
//
// One item per cycle sustained while results are taken; an accepted item goes first to
// the input register, then its status to the result register, which sets rsp.valid.
// The input register feeds the state update in slpc_core; the result register holds
// the status until taken. A stalled result holds the input register, and req.ready
// then drops once that register is full. Reset clears the pattern state and loads
// the default timing registers.
// Depends on slpc_pkg, slpc_if, slpc_cfg_regs and slpc_core.
`default_nettype none

module status_led_pattern_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  slpc_req_if.sink                        req,
  slpc_rsp_if.source                      rsp,
  input  logic                            cfg_we_i,
  input  logic [slpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [slpc_pkg::CFG_WIDTH-1:0]  cfg_wdata_i
);
  import slpc_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  logic    out_valid_q;
  status_t status_nxt;
  status_t status_q;
  logic    adv;
  logic    in_take;

  assign adv     = in_valid_q && (!out_valid_q || rsp.ready);
  assign in_take = req.valid && req.ready;

  assign req.ready = !in_valid_q || adv;

  slpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  slpc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .status_o (status_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid_q <= req.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.req_type    <= req.req_type;
      item_q.mode_code   <= req.mode_code;
      item_q.blink_count <= req.blink_count;
    end
    if (adv) begin
      status_q <= status_nxt;
    end
  end

  assign rsp.valid    = out_valid_q;
  assign rsp.led_on   = status_q.led_on;
  assign rsp.mode_now = status_q.mode_now;

endmodule

`default_nettype wire

>>> sv/slpc_checker.sv
// Port-level checks for the status LED pattern controller, bound to the top level.
// Depends on slpc_pkg and status_led_pattern_controller.
`default_nettype none

module slpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_led_on_i,
  input logic [1:0] rsp_mode_now_i
);
  import slpc_pkg::*;

  logic req_take;
  assign req_take = req_valid_i && req_ready_i;

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_led_on_i)
      && $stable(rsp_mode_now_i))
    else $error("stalled result changed");

  // Listening always shows a lit LED
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_mode_now_i == MODE_LISTEN) |-> rsp_led_on_i)
    else $error("listening with LED off");

  // A result leaves only when it was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(rsp_valid_i) |-> $past(rsp_ready_i))
    else $error("result dropped without handshake");

  // A fresh result follows an accepted item through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_take, 2))
    else $error("result without accepted item");

endmodule

bind status_led_pattern_controller slpc_checker u_slpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req.valid),
  .req_ready_i    (req.ready),
  .rsp_valid_i    (rsp.valid),
  .rsp_ready_i    (rsp.ready),
  .rsp_led_on_i   (rsp.led_on),
  .rsp_mode_now_i (rsp.mode_now)
);

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the status LED pattern controller: drives ticks and mode commands,
// predicts the LED level and mode of every item and checks each status result in order.
// Depends on slpc_pkg, slpc_if and status_led_pattern_controller.
`default_nettype none

module tb_top;
  import slpc_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_WIDTH-1:0] cfg_wdata_i;

  slpc_req_if req_ch ();
  slpc_rsp_if rsp_ch ();

  status_led_pattern_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Pattern state as the bench sees it
  cfg_t                   timing;
  mode_e                  pat_mode;
  logic [TIMER_WIDTH-1:0] pat_elapsed;
  logic                   pat_half;
  logic [BLINK_WIDTH-1:0] pat_target;
  logic [BLINK_WIDTH-1:0] pat_done;
  logic                   pat_led;

  status_t led_status_q[$];
  status_t want;
  bit      idle_on;
  int      errors;
  int      results_checked;
  int      items_sent;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic void enter_pattern(mode_e m, logic [BLINK_WIDTH-1:0] cnt);
    pat_mode    = m;
    pat_elapsed = '0;
    pat_half    = 1'b0;
    pat_done    = '0;
    pat_target  = (m == MODE_RESULT) ? cnt : '0;
    pat_led     = (m == MODE_LISTEN);
  endfunction

  function automatic void apply_tick();
    logic [TIMER_WIDTH-1:0] n;
    // advance and saturate
    n = (pat_elapsed == '1) ? pat_elapsed : pat_elapsed + 1'b1;
    case (pat_mode)
      MODE_READY: begin
        if (n >= timing.ready_len_ticks) n = '0;
        pat_elapsed = n;
        pat_led     = (n < timing.ready_on_ticks);
      end
      MODE_LISTEN: begin
        pat_elapsed = n;
        pat_led     = 1'b1;
      end
      MODE_PROC: begin
        if (n >= timing.processing_half_ms) begin
          n        = '0;
          pat_half = ~pat_half;
        end
        pat_elapsed = n;
        pat_led     = ~pat_half;
      end
      default: begin
        if (pat_done >= pat_target) begin
          enter_pattern(MODE_READY, '0);
        end else if (n < timing.result_step_ms) begin
          pat_elapsed = n;
        end else begin
          pat_elapsed = '0;
          if (!pat_led) begin
            pat_led = 1'b1;
          end else begin
            // count the blink on its falling edge
            pat_led  = 1'b0;
            pat_done = pat_done + 1'b1;
            if (pat_done >= pat_target) enter_pattern(MODE_READY, '0);
          end
        end
      end
    endcase
  endfunction

  task automatic send_item(input logic rt, input logic [1:0] mc,
                           input logic [BLINK_WIDTH-1:0] bc);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rt;
    req_ch.mode_code   <= mc;
    req_ch.blink_count <= bc;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    if (rt) enter_pattern(mode_e'(mc), bc);
    else apply_tick();
    led_status_q.push_back('{led_on: pat_led, mode_now: pat_mode});
    items_sent++;
  endtask

  // Ticks carry junk in the fields they ignore
  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_item(1'b0, 2'($urandom_range(0, 3)), BLINK_WIDTH'($urandom_range(0, 15)));
  endtask

  task automatic set_mode(input mode_e m, input int unsigned cnt);
    send_item(1'b1, m, BLINK_WIDTH'(cnt));
  endtask

  // Drop valid and hold until every status has come back
  task automatic settle();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (led_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_READY_PULSE:  timing.ready_on_ticks     = value;
      CFG_READY_PERIOD: timing.ready_len_ticks    = value;
      CFG_PROC_HALF:    timing.processing_half_ms = value;
      CFG_RESULT_STEP:  timing.result_step_ms     = value;
      default: ;
    endcase
  endtask

  task automatic set_all_timing(input logic [CFG_WIDTH-1:0] value);
    set_timing(CFG_READY_PULSE, value);
    set_timing(CFG_READY_PERIOD, value);
    set_timing(CFG_PROC_HALF, value);
    set_timing(CFG_RESULT_STEP, value);
  endtask

  // Mostly short intervals so patterns run through, with the odd extreme
  function automatic logic [CFG_WIDTH-1:0] pick_interval(input int unsigned short_max);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return CFG_WIDTH'($urandom_range(1, 65535));
      default: return CFG_WIDTH'($urandom_range(0, short_max));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_ticks(3);
    set_mode(MODE_READY, 0);
    send_ticks(2);
  endtask

  task automatic test_mode_commands();
    settle();
    set_timing(CFG_READY_PULSE, CFG_WIDTH'(2));
    set_timing(CFG_READY_PERIOD, CFG_WIDTH'(5));
    set_timing(CFG_PROC_HALF, CFG_WIDTH'(2));
    set_timing(CFG_RESULT_STEP, CFG_WIDTH'(1));
    set_mode(MODE_READY, 15);
    send_ticks(6);
    set_mode(MODE_LISTEN, 15);
    send_ticks(2);
    set_mode(MODE_PROC, 9);
    send_ticks(4);
    // zero target drops straight back to ready
    set_mode(MODE_RESULT, 0);
    send_ticks(1);
    set_mode(MODE_RESULT, 2);
    send_ticks(5);
    // interrupt a long result
    set_mode(MODE_RESULT, 15);
    send_ticks(2);
    set_mode(MODE_LISTEN, 0);
  endtask

  task automatic test_zero_timing();
    settle();
    set_all_timing('0);
    set_mode(MODE_READY, 0);
    send_ticks(2);
    set_mode(MODE_PROC, 0);
    send_ticks(3);
    set_mode(MODE_RESULT, 1);
    send_ticks(3);
    settle();
    set_timing(CFG_READY_PULSE, '1);
    set_mode(MODE_READY, 0);
    send_ticks(2);
  endtask

  task automatic test_timing_extremes();
    settle();
    set_all_timing('1);
    set_mode(MODE_READY, 0);
    send_ticks(3);
    set_mode(MODE_PROC, 0);
    send_ticks(3);
    set_mode(MODE_RESULT, 5);
    send_ticks(3);
    settle();
    set_all_timing(CFG_WIDTH'(1));
    set_mode(MODE_READY, 0);
    send_ticks(3);
    set_mode(MODE_PROC, 0);
    send_ticks(3);
    set_mode(MODE_RESULT, 2);
    send_ticks(5);
  endtask

  // A register cut below the running count ends the interval on the next tick
  task automatic test_shortened_interval();
    settle();
    set_timing(CFG_READY_PULSE, CFG_WIDTH'(3));
    set_timing(CFG_READY_PERIOD, CFG_WIDTH'(50));
    set_mode(MODE_READY, 0);
    send_ticks(20);
    settle();
    set_timing(CFG_READY_PERIOD, CFG_WIDTH'(8));
    send_ticks(3);
    settle();
    set_timing(CFG_PROC_HALF, CFG_WIDTH'(40));
    set_mode(MODE_PROC, 0);
    send_ticks(20);
    settle();
    set_timing(CFG_PROC_HALF, CFG_WIDTH'(5));
    send_ticks(3);
    settle();
    set_timing(CFG_RESULT_STEP, CFG_WIDTH'(30));
    set_mode(MODE_RESULT, 3);
    send_ticks(10);
    settle();
    set_timing(CFG_RESULT_STEP, CFG_WIDTH'(4));
    send_ticks(3);
  endtask

  task automatic test_unused_index();
    settle();
    set_timing(CFG_PROC_HALF, CFG_WIDTH'(3));
    for (int i = int'(CFG_RESULT_STEP) + 1; i < 2 ** CFG_IDX_W; i++)
      set_timing(CFG_IDX_W'(i), CFG_WIDTH'($urandom_range(0, 65535)));
    set_mode(MODE_PROC, 0);
    send_ticks(7);
  endtask

  task automatic test_random_traffic();
    int stay;
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      set_timing(CFG_READY_PULSE, pick_interval(12));
      set_timing(CFG_READY_PERIOD, pick_interval(16));
      set_timing(CFG_PROC_HALF, pick_interval(10));
      set_timing(CFG_RESULT_STEP, pick_interval(5));
      idle_on = (phase < 9) && ($urandom_range(0, 3) != 0);
      stay    = $urandom_range(3, 40);
      for (int k = 0; k < 110; k++) begin
        if ($urandom_range(1, stay) == 1)
          send_item(1'b1, 2'($urandom_range(0, 3)), BLINK_WIDTH'($urandom_range(0, 15)));
        else
          send_ticks(1);
        if (k == 60 && phase % 3 == 1) settle();
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (led_status_q.size() == 0) begin
        errors++;
        $display("%0t: status result with nothing outstanding: led %0b mode %0d",
                 $time, rsp_ch.led_on, rsp_ch.mode_now);
      end else begin
        want = led_status_q.pop_front();
        results_checked++;
        if (rsp_ch.led_on !== want.led_on) begin
          errors++;
          $display("%0t: led_on mismatch, expected %0b actual %0b",
                   $time, want.led_on, rsp_ch.led_on);
        end
        if (rsp_ch.mode_now !== want.mode_now) begin
          errors++;
          $display("%0t: mode_now mismatch, expected %0d actual %0d",
                   $time, want.mode_now, rsp_ch.mode_now);
        end
      end
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    #(8 * 4000000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_wdata_i        = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = 1'b0;
    req_ch.mode_code   = '0;
    req_ch.blink_count = '0;
    errors             = 0;
    results_checked    = 0;
    items_sent         = 0;
    idle_on            = 1'b1;
    timing.ready_on_ticks     = RST_READY_PULSE;
    timing.ready_len_ticks    = RST_READY_PERIOD;
    timing.processing_half_ms = RST_PROC_HALF;
    timing.result_step_ms     = RST_RESULT_STEP;
    enter_pattern(MODE_READY, '0);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_mode_commands();
    test_zero_timing();
    test_timing_extremes();
    test_shortened_interval();
    test_unused_index();
    test_random_traffic();
    settle();

    $display("Sent %0d items and checked %0d status results, %0d mismatches.",
             items_sent, results_checked, errors);
    $display("Covered all modes, zero and full-scale timing, cut intervals and stray indexes.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
